@@ sv/asp_pkg.sv @@
`default_nettype none
package asp_pkg;

	typedef enum logic [2:0] {
		MODE_STEP     = 3'd0,
		MODE_TOUCH    = 3'd1,
		MODE_POLL     = 3'd2,
		MODE_ARM      = 3'd3,
		MODE_DISARM   = 3'd4,
		MODE_STOP     = 3'd5,
		MODE_FAR_STOP = 3'd6,
		MODE_RESTART  = 3'd7
	} mode_t;

	typedef enum logic [1:0] {
		ACT_NONE   = 2'd0,
		ACT_ARM    = 2'd1,
		ACT_DISARM = 2'd2
	} action_t;

	// register indexes on the config port
	localparam logic REG_SETTLE_TIME     = 1'b0;
	localparam logic REG_TOUCH_DEAD_TIME = 1'b1;

	localparam logic [31:0] SETTLE_TIME_RST     = 32'd0;
	localparam logic [31:0] TOUCH_DEAD_TIME_RST = 32'd500;

	// x / 1000 == (x * DIV_MAGIC) >> DIV_SHIFT for every 32-bit x
	localparam logic [31:0] DIV_MAGIC = 32'h1062_4DD3;
	localparam int          DIV_SHIFT = 38;

	typedef struct packed {
		action_t     action;
		logic        armed;
		logic        settling;
		logic        stop;
		logic        dead;
		logic        hb_ok;
		logic [31:0] stops;
		logic [31:0] run_ms;   // elapsed ms of current or last run
	} core_res_t;

	typedef struct packed {
		action_t     action;
		logic        armed;
		logic        settling;
		logic        stop;
		logic        dead;
		logic        hb_ok;
		logic [31:0] stops;
		logic [22:0] run_sec;
	} out_res_t;

endpackage
`default_nettype wire

@@ sv/asp_core.sv @@
`default_nettype none
module asp_core
	import asp_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        fire,
	input  wire mode_t       mode,
	input  wire logic [31:0] now_time,
	input  wire logic [31:0] settle_time,
	input  wire logic [31:0] touch_dead_time,
	output core_res_t        res_s2
);

	logic [31:0] last_touch_q, deadline_q, run_start_q, run_ms_q, stop_total_q;
	logic        stop_q, settling_q, armed_q, dead_before_q, owed_q;

	logic [31:0] last_touch_n, deadline_n, run_start_n, run_ms_n, stop_total_n;
	logic        stop_n, settling_n, armed_n, dead_before_n, owed_n;
	action_t     act;

	logic        dead_now, dead_rise, owed_poll, reached, dead_out;

	assign dead_now  = (now_time - last_touch_q) >= touch_dead_time;
	assign dead_rise = dead_now && !dead_before_q;
	assign owed_poll = owed_q || (dead_rise && armed_q);
	// deadline reached: (deadline - now) is zero or negative as signed
	assign reached   = (deadline_q - now_time - 32'd1) >= 32'h7FFF_FFFF;

	always_comb begin
		last_touch_n  = last_touch_q;
		deadline_n    = deadline_q;
		run_start_n   = run_start_q;
		run_ms_n      = run_ms_q;
		stop_total_n  = stop_total_q;
		stop_n        = stop_q;
		settling_n    = settling_q;
		armed_n       = armed_q;
		dead_before_n = dead_before_q;
		owed_n        = owed_q;
		act           = ACT_NONE;
		unique case (mode)
			MODE_STEP: begin
				stop_total_n  = stop_total_q + {31'd0, dead_rise};
				dead_before_n = dead_now;
				settling_n    = settling_q && !dead_rise;
				owed_n        = 1'b0;
				if (owed_poll && armed_q) begin
					armed_n     = 1'b0;
					settling_n  = 1'b0;
					run_start_n = 32'd0;
					act         = ACT_DISARM;
				end else begin
					if ((dead_now || stop_q) && armed_q) begin
						armed_n    = 1'b0;
						settling_n = 1'b0;
						act        = ACT_DISARM;
					end
					if (settling_n && reached) begin
						settling_n = 1'b0;
						if (!stop_q && !dead_now) begin
							armed_n = 1'b1;
							act     = ACT_ARM;
						end
					end
					if (armed_n) begin
						// zero start means not started
						run_start_n = (run_start_q == 32'd0) ? now_time : run_start_q;
						run_ms_n    = now_time - run_start_n;
					end else begin
						run_start_n = 32'd0;
					end
				end
			end
			MODE_TOUCH: begin
				last_touch_n = now_time;
			end
			MODE_POLL: begin
				stop_total_n  = stop_total_q + {31'd0, dead_rise};
				dead_before_n = dead_now;
				settling_n    = settling_q && !dead_rise;
				owed_n        = owed_poll;
			end
			MODE_ARM: begin
				if (!dead_now) begin
					stop_n     = 1'b0;
					settling_n = 1'b1;
					deadline_n = now_time + settle_time;
				end
			end
			MODE_DISARM: begin
				settling_n = 1'b0;
				armed_n    = 1'b0;
			end
			MODE_STOP: begin
				stop_n       = 1'b1;
				stop_total_n = stop_total_q + 32'd1;
				settling_n   = 1'b0;
			end
			MODE_FAR_STOP: begin
				stop_n       = 1'b1;
				stop_total_n = stop_total_q + 32'd1;
				settling_n   = 1'b0;
				armed_n      = 1'b0;
			end
			MODE_RESTART: begin
				last_touch_n  = now_time;
				deadline_n    = 32'd0;
				run_start_n   = 32'd0;
				run_ms_n      = 32'd0;
				stop_total_n  = 32'd0;
				stop_n        = 1'b0;
				settling_n    = 1'b0;
				armed_n       = 1'b0;
				dead_before_n = 1'b0;
				owed_n        = 1'b0;
			end
			default: begin
			end
		endcase
	end

	// touch and restart move last-touch to now: age zero
	assign dead_out = (mode == MODE_TOUCH || mode == MODE_RESTART) ?
		(touch_dead_time == 32'd0) : dead_now;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_touch_q  <= 32'd0;
			deadline_q    <= 32'd0;
			run_start_q   <= 32'd0;
			run_ms_q      <= 32'd0;
			stop_total_q  <= 32'd0;
			stop_q        <= 1'b0;
			settling_q    <= 1'b0;
			armed_q       <= 1'b0;
			dead_before_q <= 1'b0;
			owed_q        <= 1'b0;
		end else if (fire) begin
			last_touch_q  <= last_touch_n;
			deadline_q    <= deadline_n;
			run_start_q   <= run_start_n;
			run_ms_q      <= run_ms_n;
			stop_total_q  <= stop_total_n;
			stop_q        <= stop_n;
			settling_q    <= settling_n;
			armed_q       <= armed_n;
			dead_before_q <= dead_before_n;
			owed_q        <= owed_n;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_s2.action   <= act;
			res_s2.armed    <= armed_n;
			res_s2.settling <= settling_n;
			res_s2.stop     <= stop_n;
			res_s2.dead     <= dead_out;
			res_s2.hb_ok    <= !stop_n && !dead_out;
			res_s2.stops    <= stop_total_n;
			res_s2.run_ms   <= run_ms_n;
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!fire |=> $stable(stop_total_q) && $stable(armed_q) && $stable(settling_q))
		else $error("state moved without an item");
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		fire && mode == MODE_RESTART |=> stop_total_q == 32'd0 && !armed_q && !owed_q)
		else $error("restart left state behind");
	a_far_stop: assert property (@(posedge clk) disable iff (!arst_n)
		fire && mode == MODE_FAR_STOP |=> stop_q && !armed_q && !settling_q)
		else $error("far stop did not latch and disarm");
	a_arm_stop: assert property (@(posedge clk) disable iff (!arst_n)
		fire && mode == MODE_STEP && act == ACT_ARM |-> !stop_q && !dead_now)
		else $error("armed while stopped or touch dead");

endmodule
`default_nettype wire

@@ sv/asp_div.sv @@
`default_nettype none
module asp_div
	import asp_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      load,
	input  wire core_res_t res_s2,
	output out_res_t       res_s3
);

	logic [63:0] prod;
	logic [22:0] quot;

	// ms to whole seconds by reciprocal multiply
	assign prod = {32'd0, res_s2.run_ms} * {32'd0, DIV_MAGIC};
	assign quot = 23'(prod >> DIV_SHIFT);

	always_ff @(posedge clk) begin
		if (load) begin
			res_s3.action   <= res_s2.action;
			res_s3.armed    <= res_s2.armed;
			res_s3.settling <= res_s2.settling;
			res_s3.stop     <= res_s2.stop;
			res_s3.dead     <= res_s2.dead;
			res_s3.hb_ok    <= res_s2.hb_ok;
			res_s3.stops    <= res_s2.stops;
			res_s3.run_sec  <= quot;
		end
	end

endmodule
`default_nettype wire

@@ sv/arming_safety_policy.sv @@
`default_nettype none
// Channel   Dir  Handshake          Payload
// s_        in   s_tvalid/s_tready  s_tuser[2:0] mode, s_tdata[31:0] now_time
// m_        out  m_tvalid/m_tready  m_tdata[63:0] result fields
// cfg_      in   cfg_we             cfg_index selects register, cfg_data value
//
// One result per transfer in, one transfer per cycle sustained while m_tready stays high.
// The pipeline has an input register, the policy update and the ms-to-seconds
// multiply into the output register.
// The policy state updates as each item fires, so back-to-back items see each
// other's effects. Stalls on m_ back up through the stage valids to s_tready.
// arst_n clears state, valids and config (settle 0 ms, dead time 500 ms).
module arming_safety_policy
	import asp_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,   // [31:0] now_time
	input  wire logic [2:0]  s_tuser,   // [2:0] mode
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// [1:0] action, [2] is_armed, [3] is_settling, [4] stop_latched,
	// [5] touch_is_dead, [6] heartbeat_ok, [38:7] stops_seen,
	// [61:39] run_time_seconds, [63:62] zero
	output logic [63:0]      m_tdata,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [31:0] cfg_data
);

	logic [31:0] settle_time_q, touch_dead_time_q;
	logic        v1_q, v2_q, v3_q;
	logic        rdy2, rdy3, fire;
	mode_t       mode_s1;
	logic [31:0] now_s1;
	core_res_t   res_s2;
	out_res_t    res_s3;

	// config writes are to come only while idle; the block does not enforce this
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settle_time_q     <= SETTLE_TIME_RST;
			touch_dead_time_q <= TOUCH_DEAD_TIME_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SETTLE_TIME:     settle_time_q     <= cfg_data;
				REG_TOUCH_DEAD_TIME: touch_dead_time_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// each stage loads when empty or when its contents move on
	assign rdy3     = !v3_q || m_tready;
	assign rdy2     = !v2_q || rdy3;
	assign s_tready = !v1_q || rdy2;
	assign fire     = v1_q && rdy2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
		end else begin
			if (s_tready) v1_q <= s_tvalid;
			if (rdy2)     v2_q <= v1_q;
			if (rdy3)     v3_q <= v2_q;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			mode_s1 <= mode_t'(s_tuser);
			now_s1  <= s_tdata;
		end
	end

	asp_core u_core (
		.clk             (clk),
		.arst_n          (arst_n),
		.fire            (fire),
		.mode            (mode_s1),
		.now_time        (now_s1),
		.settle_time     (settle_time_q),
		.touch_dead_time (touch_dead_time_q),
		.res_s2          (res_s2)
	);

	asp_div u_div (
		.clk    (clk),
		.load   (v2_q && rdy3),
		.res_s2 (res_s2),
		.res_s3 (res_s3)
	);

	assign m_tvalid = v3_q;
	assign m_tdata  = {2'b00, res_s3.run_sec, res_s3.stops, res_s3.hb_ok, res_s3.dead,
		res_s3.stop, res_s3.settling, res_s3.armed, res_s3.action};

	a_in_free: assert property (@(posedge clk) disable iff (!arst_n)
		!v1_q |-> s_tready)
		else $error("empty input stage refused a transfer");
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		v3_q && m_tready && !v2_q |=> !v3_q)
		else $error("output kept a result already taken");
	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> v2_q)
		else $error("processed item lost between stages");

endmodule
`default_nettype wire
